FILE: src/perlin_gradient_noise_3d_defines.svh
// assertion macros shared by the noise pipeline
`ifndef PERLIN_GRADIENT_NOISE_3D_DEFINES_SVH
`define PERLIN_GRADIENT_NOISE_3D_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define PGN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define PGN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/pgn3d_pkg.sv
// constants, types and helpers for the 3d gradient noise pipeline
`timescale 1ns / 1ps
package pgn3d_pkg;
  localparam int TableSize = 256;
  localparam int IdxW = $clog2(TableSize);
  localparam int FracBits = 16;
  localparam int OutW = 18;
  localparam int CoordW = 32;
  localparam int OffW = FracBits + 2;
  localparam int ValW = FracBits + 4;
  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic signed [OffW-1:0] off_t;
  typedef logic signed [ValW-1:0] val_t;
  typedef logic [FracBits:0] fade_t;

  function automatic val_t grad_f(input logic [3:0] h, input off_t x, input off_t y,
                                  input off_t z);
    off_t u;
    off_t v;
    val_t su;
    val_t sv;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    su = ValW'(u);
    sv = ValW'(v);
    if (h[0]) su = -su;
    if (h[1]) sv = -sv;
    return su + sv;
  endfunction

  // a + floor(f*(b-a)/2^F)
  function automatic val_t lerp_f(input val_t a, input val_t b, input fade_t f);
    logic signed [ValW+FracBits+2:0] p;
    val_t d;
    d = b - a;
    p = $signed({1'b0, f}) * d;
    return a + ValW'(p >>> FracBits);
  endfunction
endpackage

FILE: src/pgn3d_if.sv
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface pgn3d_in_if;
  import pgn3d_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [7:0] table_index;
  logic [7:0] table_value;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;
  modport source(output valid, op, table_index, table_value, coord_x, coord_y, coord_z,
                 input ready);
  modport sink(input valid, op, table_index, table_value, coord_x, coord_y, coord_z,
               output ready);
endinterface

interface pgn3d_out_if;
  import pgn3d_pkg::*;
  logic valid;
  logic ready;
  logic signed [OutW-1:0] noise_value;
  modport source(output valid, noise_value, input ready);
  modport sink(input valid, noise_value, output ready);
endinterface

FILE: src/perlin_gradient_noise_3d.sv
// top level of the 3d improved gradient noise pipeline
//
// in channel: op load writes table_value at table_index; op evaluate takes signed
// Q16.16 coord_x, coord_y, coord_z and gives one noise_value on the out channel.
// every table entry that a coordinate touches must be loaded first.
// one transaction per cycle while the output is not stalled; each evaluate passes
// through three table lookup stages (the fade runs alongside), the gradient stage
// and three interpolation stages, the last with saturation.
// loads take effect in order: an evaluate sees every earlier load and no later one.
// the pipeline moves only when the output register is empty or being taken, so a
// stalled receiver freezes every stage and nothing is lost or repeated.
// reset clears stage valid bits only; the table holds garbage until written.
// each lookup stage reads its own table copies, two entries per copy per cycle,
// and a load writes each copy as it passes the stage that reads that copy.
`timescale 1ns / 1ps
`include "perlin_gradient_noise_3d_defines.svh"
module perlin_gradient_noise_3d (
  input logic clk,
  input logic rst_n,
  pgn3d_in_if.sink in_ch,
  pgn3d_out_if.source out_ch
);
  import pgn3d_pkg::*;
  localparam int Nst = 7;
  logic adv;
  logic [Nst-1:0] v_r;
  idx_t tab_a [TableSize];
  idx_t tab_b [TableSize];
  idx_t tab_c [TableSize];
  idx_t tab_d [TableSize];
  idx_t tab_e [TableSize];
  idx_t tab_f [TableSize];
  idx_t tab_g [TableSize];
  logic wr;
  logic ld1_r, ld2_r;
  idx_t li1_r, li2_r, lv1_r, lv2_r;
  idx_t cx_s;
  idx_t pa_r, pb_r, cy1_r, cz1_r, cz2_r;
  idx_t qa0_r, qa1_r, qb0_r, qb1_r;
  idx_t a_s, b_s, aa_s, ab_s, ba_s, bb_s;
  off_t x_r [1:3];
  off_t y_r [1:3];
  off_t z_r [1:3];
  idx_t h_r [8];
  fade_t fu, fv, fw;
  fade_t fu4_r, fv4_r, fv5_r, fw4_r, fw5_r, fw6_r;
  val_t g_r [8];
  val_t l5_r [4];
  val_t l6_r [2];
  logic signed [OutW-1:0] o_r;
  val_t r7;
  off_t xo, yo, zo, x1o, y1o, z1o;
  logic signed [FracBits:0] tx, ty, tz;

  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign wr = in_ch.valid && in_ch.ready && in_ch.op == OpLoad;
  assign out_ch.valid = v_r[Nst-1];
  assign out_ch.noise_value = o_r;

  // table copies, each written when the load passes its read stage
  always_ff @(posedge clk) begin
    if (wr) begin
      tab_a[in_ch.table_index[IdxW-1:0]] <= in_ch.table_value;
    end
    if (adv && ld1_r) begin
      tab_b[li1_r] <= lv1_r;
      tab_c[li1_r] <= lv1_r;
    end
    if (adv && ld2_r) begin
      tab_d[li2_r] <= lv2_r;
      tab_e[li2_r] <= lv2_r;
      tab_f[li2_r] <= lv2_r;
      tab_g[li2_r] <= lv2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      ld1_r <= 1'b0;
      ld2_r <= 1'b0;
    end else if (adv) begin
      v_r <= {v_r[Nst-2:0], in_ch.valid && in_ch.op == OpEval};
      ld1_r <= in_ch.valid && in_ch.op == OpLoad;
      ld2_r <= ld1_r;
    end
  end

  assign tx = $signed({1'b0, in_ch.coord_x[FracBits-1:0]});
  assign ty = $signed({1'b0, in_ch.coord_y[FracBits-1:0]});
  assign tz = $signed({1'b0, in_ch.coord_z[FracBits-1:0]});
  assign cx_s = in_ch.coord_x[FracBits +: IdxW];

  pgn3d_fade u_fx (.clk(clk), .en(adv), .t(in_ch.coord_x[FracBits-1:0]), .fade(fu));
  pgn3d_fade u_fy (.clk(clk), .en(adv), .t(in_ch.coord_y[FracBits-1:0]), .fade(fv));
  pgn3d_fade u_fz (.clk(clk), .en(adv), .t(in_ch.coord_z[FracBits-1:0]), .fade(fw));

  always_comb begin
    a_s = pa_r + cy1_r;
    b_s = pb_r + cy1_r;
    aa_s = qa0_r + cz2_r;
    ab_s = qa1_r + cz2_r;
    ba_s = qb0_r + cz2_r;
    bb_s = qb1_r + cz2_r;
    xo = x_r[3];
    yo = y_r[3];
    zo = z_r[3];
    x1o = xo - off_t'(1 << FracBits);
    y1o = yo - off_t'(1 << FracBits);
    z1o = zo - off_t'(1 << FracBits);
    r7 = lerp_f(l6_r[0], l6_r[1], fw6_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: x lookups, capture cell and fraction
      pa_r <= tab_a[cx_s];
      pb_r <= tab_a[cx_s + idx_t'(1)];
      cy1_r <= in_ch.coord_y[FracBits +: IdxW];
      cz1_r <= in_ch.coord_z[FracBits +: IdxW];
      li1_r <= in_ch.table_index[IdxW-1:0];
      lv1_r <= in_ch.table_value;
      x_r[1] <= OffW'(tx);
      y_r[1] <= OffW'(ty);
      z_r[1] <= OffW'(tz);
      // stage 2: lookups at a, a+1, b, b+1
      qa0_r <= tab_b[a_s];
      qa1_r <= tab_b[a_s + idx_t'(1)];
      qb0_r <= tab_c[b_s];
      qb1_r <= tab_c[b_s + idx_t'(1)];
      cz2_r <= cz1_r;
      li2_r <= li1_r;
      lv2_r <= lv1_r;
      x_r[2] <= x_r[1]; y_r[2] <= y_r[1]; z_r[2] <= z_r[1];
      // stage 3: corner hashes, order aa ba ab bb then z+1
      h_r[0] <= tab_d[aa_s];
      h_r[1] <= tab_e[ba_s];
      h_r[2] <= tab_f[ab_s];
      h_r[3] <= tab_g[bb_s];
      h_r[4] <= tab_d[aa_s + idx_t'(1)];
      h_r[5] <= tab_e[ba_s + idx_t'(1)];
      h_r[6] <= tab_f[ab_s + idx_t'(1)];
      h_r[7] <= tab_g[bb_s + idx_t'(1)];
      x_r[3] <= x_r[2]; y_r[3] <= y_r[2]; z_r[3] <= z_r[2];
      // stage 4: gradients; fade results arrive alongside stage 3
      g_r[0] <= grad_f(h_r[0][3:0], xo, yo, zo);
      g_r[1] <= grad_f(h_r[1][3:0], x1o, yo, zo);
      g_r[2] <= grad_f(h_r[2][3:0], xo, y1o, zo);
      g_r[3] <= grad_f(h_r[3][3:0], x1o, y1o, zo);
      g_r[4] <= grad_f(h_r[4][3:0], xo, yo, z1o);
      g_r[5] <= grad_f(h_r[5][3:0], x1o, yo, z1o);
      g_r[6] <= grad_f(h_r[6][3:0], xo, y1o, z1o);
      g_r[7] <= grad_f(h_r[7][3:0], x1o, y1o, z1o);
      fu4_r <= fu;
      fv4_r <= fv;
      fw4_r <= fw;
      // stage 5: x lerps
      l5_r[0] <= lerp_f(g_r[0], g_r[1], fu4_r);
      l5_r[1] <= lerp_f(g_r[2], g_r[3], fu4_r);
      l5_r[2] <= lerp_f(g_r[4], g_r[5], fu4_r);
      l5_r[3] <= lerp_f(g_r[6], g_r[7], fu4_r);
      fv5_r <= fv4_r;
      fw5_r <= fw4_r;
      // stage 6: y lerps
      l6_r[0] <= lerp_f(l5_r[0], l5_r[1], fv5_r);
      l6_r[1] <= lerp_f(l5_r[2], l5_r[3], fv5_r);
      fw6_r <= fw5_r;
      // stage 7: z lerp and saturate
      if (r7 > val_t'((1 << (OutW-1)) - 1)) o_r <= OutW'((1 << (OutW-1)) - 1);
      else if (r7 < -val_t'(1 << (OutW-1))) o_r <= OutW'(-(1 << (OutW-1)));
      else o_r <= OutW'(r7);
    end
  end

  `PGN_ASSERT_IMP(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `PGN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.noise_value))
  `PGN_ASSERT_NEXT(a_load_no_out, clk, rst_n, adv && !v_r[Nst-2], !out_ch.valid)
endmodule

FILE: src/pgn3d_fade.sv
// quintic fade pipeline, three register stages
`timescale 1ns / 1ps
module pgn3d_fade (
  input  logic clk,
  input  logic en,
  input  logic [pgn3d_pkg::FracBits-1:0] t,
  output pgn3d_pkg::fade_t fade
);
  import pgn3d_pkg::*;
  localparam logic [FracBits+4:0] One15 = (FracBits+5)'(15 * (1 << FracBits));
  localparam logic [FracBits+4:0] One10 = (FracBits+5)'(10 * (1 << FracBits));
  localparam logic [FracBits+4:0] Lim = (FracBits+5)'(1 << FracBits);
  logic [FracBits-1:0] t1_r, c_r;
  logic [FracBits+4:0] e1_r, e2_r;
  logic [FracBits-1:0] d_r;
  fade_t f_r;
  logic [2*FracBits-1:0] cc;
  logic [2*FracBits-1:0] dd;
  logic [2*FracBits+4:0] ee;
  logic [2*FracBits+4:0] ff;
  logic [FracBits+4:0] s;
  always_comb begin
    cc = t * t;
    s = One15 - (FracBits+5)'(6 * t);
    ee = t * s;
    dd = c_r * t1_r;
    ff = d_r * e2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t;
      c_r <= cc[2*FracBits-1:FracBits];
      e1_r <= One10 - (FracBits+5)'(ee >> FracBits);
      d_r <= dd[2*FracBits-1:FracBits];
      e2_r <= e1_r;
      f_r <= ((ff >> FracBits) > (2*FracBits+5)'(Lim)) ? fade_t'(Lim)
             : fade_t'(ff >> FracBits);
    end
  end
  assign fade = f_r;
endmodule

FILE: sim/testbench.sv
// self-checking testbench for the 3d gradient noise pipeline
`timescale 1ns / 1ps
module testbench;
  import pgn3d_pkg::*;

  logic clk;
  logic rst_n;

  pgn3d_in_if in_ch();
  pgn3d_out_if out_ch();

  perlin_gradient_noise_3d DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  localparam int StallLimit = 5000;

  logic [7:0] perm_copy [TableSize];
  logic signed [OutW-1:0] noise_expected_q[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // quintic fade on a Q0.16 fraction
  function automatic longint fade_of(input longint t);
    longint c;
    longint d;
    longint e;
    longint f;
    c = (t * t) >>> FracBits;
    d = (c * t) >>> FracBits;
    e = 10 * 65536 - ((t * (15 * 65536 - 6 * t)) >>> FracBits);
    f = (d * e) >>> FracBits;
    if (f > 65536) f = 65536;
    return f;
  endfunction

  function automatic longint corner_dot(input int hash, input longint x, input longint y,
                                        input longint z);
    int h;
    longint u;
    longint v;
    h = hash & 15;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    if (h & 1) u = -u;
    if (h & 2) v = -v;
    return u + v;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint f);
    return a + ((f * (b - a)) >>> FracBits);
  endfunction

  function automatic int perm_at(input int i);
    return perm_copy[i & (TableSize - 1)];
  endfunction

  function automatic logic signed [OutW-1:0] noise_at(input logic signed [31:0] cx_in,
                                                      input logic signed [31:0] cy_in,
                                                      input logic signed [31:0] cz_in);
    int cx, cy, cz, a, aa, ab, b, ba, bb;
    longint x, y, z, u, v, w, x1, y1, z1, r;
    cx = cx_in[23:16];
    cy = cy_in[23:16];
    cz = cz_in[23:16];
    x = cx_in[15:0];
    y = cy_in[15:0];
    z = cz_in[15:0];
    u = fade_of(x);
    v = fade_of(y);
    w = fade_of(z);
    x1 = x - 65536;
    y1 = y - 65536;
    z1 = z - 65536;
    a = perm_at(cx) + cy;
    aa = perm_at(a) + cz;
    ab = perm_at(a + 1) + cz;
    b = perm_at(cx + 1) + cy;
    ba = perm_at(b) + cz;
    bb = perm_at(b + 1) + cz;
    r = blend(
      blend(blend(corner_dot(perm_at(aa), x, y, z), corner_dot(perm_at(ba), x1, y, z), u),
            blend(corner_dot(perm_at(ab), x, y1, z), corner_dot(perm_at(bb), x1, y1, z), u),
            v),
      blend(blend(corner_dot(perm_at(aa + 1), x, y, z1),
                  corner_dot(perm_at(ba + 1), x1, y, z1), u),
            blend(corner_dot(perm_at(ab + 1), x, y1, z1),
                  corner_dot(perm_at(bb + 1), x1, y1, z1), u), v),
      w);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return OutW'(r);
  endfunction

  // one transaction on the input channel; valid stays high afterwards
  task automatic send_item(input logic op, input logic [7:0] idx, input logic [7:0] value,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.table_index <= idx;
    in_ch.table_value <= value;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OpLoad) perm_copy[idx] = value;
    else noise_expected_q.push_back(noise_at(x, y, z));
  endtask

  task automatic send_eval(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    send_item(OpEval, 8'($urandom), 8'($urandom), x, y, z);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (noise_expected_q.size() != 0) @(posedge clk);
  endtask

  // result side: checks each result, random ready, long hold-off on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (noise_expected_q.size() == 0) begin
          $display("%0t: unexpected noise transaction, actual %0d", $time,
                   out_ch.noise_value);
          mismatch_count++;
        end else begin
          if (out_ch.noise_value !== noise_expected_q[0]) begin
            $display("%0t: noise_value expected %0d actual %0d", $time,
                     noise_expected_q[0], out_ch.noise_value);
            mismatch_count++;
          end
          void'(noise_expected_q.pop_front());
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_table_load();
    int order [TableSize];
    int j, tmp;
    for (int i = 0; i < TableSize; i++) order[i] = i;
    for (int i = TableSize - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < TableSize; i++) send_item(OpLoad, 8'(i), 8'(order[i]), '0, '0, '0);
  endtask

  task automatic test_corner_coords();
    send_eval(32'h0, 32'h0, 32'h0);
    send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_eval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_eval(32'h00FF_8000, 32'h00FF_FFFF, 32'h00FF_0001);
    send_eval(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_eval(32'h7FFF_0000, 32'h8000_FFFF, 32'h0001_0000);
    send_eval(32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_8000);
    send_eval(32'h1234_4000, 32'hEDCB_C000, 32'h00FF_FFFF);
    // entries with high nibbles set, gradient taken from low bits only
    send_item(OpLoad, 8'd0, 8'hF3, '0, '0, '0);
    send_item(OpLoad, 8'd255, 8'hAE, '0, '0, '0);
    send_eval(32'h00FF_4000, 32'h00FF_C000, 32'h00FF_2000);
    send_eval(32'h0000_2000, 32'h0000_6000, 32'h0000_A000);
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) send_item(OpLoad, 8'($urandom), 8'($urandom), $urandom,
                                            $urandom, $urandom);
      else send_eval($urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_output_backpressure();
    hold_off_left = 300;
    for (int i = 0; i < 40; i++) send_eval($urandom, $urandom, $urandom);
  endtask

  task automatic test_drain_pause();
    stop_sending();
    wait_drained();
    for (int i = 0; i < 10; i++) send_eval($urandom, $urandom, $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OpLoad;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_corner_coords();
    send_idle_pct = 38;
    recv_idle_pct = 78;
    test_random_mix(160);
    send_idle_pct = 78;
    recv_idle_pct = 38;
    test_random_mix(160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(160);
    test_output_backpressure();
    test_drain_pause();
    stop_sending();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && noise_expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
